FILE: sv/rc4_pkg.sv
// RC4 engine package: transaction payload types, action codes, state encoding.
// Used by rc4_stream_cipher_top; no other dependencies.
package rc4_pkg;

    // Permutation size and last index
    localparam int          PERM_DEPTH        = 256;
    localparam logic [7:0]  PERM_LAST         = 8'hFF;

    // Key store defaults
    localparam int          KEY_MAX_BYTES_DEF = 256;
    localparam logic [8:0]  KEY_LEN_RESET     = 9'd16;

    // Action codes
    localparam logic [1:0]  ACT_KEY_WRITE     = 2'd0;
    localparam logic [1:0]  ACT_INIT          = 2'd1;
    localparam logic [1:0]  ACT_CRYPT         = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] key_index;
        logic [7:0] value;
    } t_rc4_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       not_ready;
    } t_rc4_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_SWAP,
        ST_KS_FIN,
        ST_CR_J,
        ST_CR_T
    } t_state;

endpackage

FILE: sv/rc4_stream_cipher_top.sv
// RC4 stream cipher engine: key store, permutation memory and control sequencer.
// Depends on rc4_pkg for payload types, action codes and state encoding.
//
//   channel   direction  signals                        handshake
//   command   in         start, busy, i_cmd             taken when start && !busy
//   result    out        o_result_valid, o_result       one-cycle strobe, no stall
//   config    in         i_cfg_we, i_cfg_data           written when i_cfg_we
//
// Crypt transaction: states ST_CR_J and ST_CR_T (three dependent reads through the
// single read port of the permutation memory); the final swap write lands in the
// idle cycle that also registers the result, which shows on the following cycle.
// Key write: stored on accept, engine stays idle. Init: ST_FILL writes all 256
// identity entries, then ST_KS_RD/ST_KS_J/ST_KS_SWAP per entry, then ST_KS_FIN.
// Reset (synchronous) clears counters and control, sets key_length to 16; memories
// keep their contents. The result side cannot stall; results are one cycle wide.
module rc4_stream_cipher_top
    import rc4_pkg::*;
#(
    parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_rc4_in  i_cmd,
    input  logic     i_cfg_we,
    input  logic [8:0] i_cfg_data,
    output logic     o_result_valid,
    output t_rc4_out o_result
);

    localparam int KA_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

    // Control and datapath registers
    t_state          r_state, n_state;
    logic [8:0]      r_key_length;
    logic [8:0]      r_klen, n_klen;
    logic [7:0]      r_k, n_k;
    logic [KA_W-1:0] r_kidx, n_kidx;
    logic [7:0]      r_i, n_i;
    logic [7:0]      r_j, n_j;
    logic [7:0]      r_sk, n_sk;
    logic [7:0]      r_val, n_val;
    logic            r_hit, n_hit;
    logic            r_fin, n_fin;
    logic            r_keyed, n_keyed;
    logic            r_valid, n_valid;
    t_rc4_out        r_out, n_out;

    // Memory ports
    logic [7:0]      perm_mem [PERM_DEPTH];
    logic [7:0]      key_mem  [KEY_MAX_BYTES];
    logic [7:0]      r_perm_q;
    logic            r_byp;
    logic [7:0]      r_byp_d;
    logic [7:0]      r_key_q;
    logic [7:0]      p_ra, p_wa, p_wd, p_rd;
    logic            p_we;
    logic            k_we;

    logic            accept;
    logic [7:0]      j_new;
    logic [7:0]      t_addr;
    logic [7:0]      ks;
    logic [8:0]      eff_len;

    assign accept         = start && !busy;
    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_result       = r_out;

    // Clamp key length into 1..KEY_MAX_BYTES
    always_comb begin
        if (r_key_length == 9'd0) begin
            eff_len = 9'd1;
        end else if (r_key_length > 9'(KEY_MAX_BYTES)) begin
            eff_len = 9'(KEY_MAX_BYTES);
        end else begin
            eff_len = r_key_length;
        end
    end

    // Permutation memory: one read, one write, write-first via bypass
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            perm_mem[p_wa] <= p_wd;
        end
        r_perm_q <= perm_mem[p_ra];
        r_byp_d  <= p_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= p_we && (p_wa == p_ra);
        end
    end

    assign p_rd = r_byp ? r_byp_d : r_perm_q;

    // Key store: written by key-write transactions, read at the schedule key index
    assign k_we = accept && (i_cmd.action == ACT_KEY_WRITE)
               && ({1'b0, i_cmd.key_index} < 9'(KEY_MAX_BYTES));

    always_ff @(posedge i_clk) begin
        if (k_we) begin
            key_mem[i_cmd.key_index[KA_W-1:0]] <= i_cmd.value;
        end
        r_key_q <= key_mem[r_kidx];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd.action == ACT_INIT)) begin
                    n_state = ST_FILL;
                end else if (accept && (i_cmd.action == ACT_CRYPT) && r_keyed) begin
                    n_state = ST_CR_J;
                end
            end
            ST_FILL:    n_state = (r_k == PERM_LAST) ? ST_KS_RD : ST_FILL;
            ST_KS_RD:   n_state = ST_KS_J;
            ST_KS_J:    n_state = ST_KS_SWAP;
            ST_KS_SWAP: n_state = (r_k == PERM_LAST) ? ST_KS_FIN : ST_KS_RD;
            ST_KS_FIN:  n_state = ST_IDLE;
            ST_CR_J:    n_state = ST_CR_T;
            ST_CR_T:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_klen  = r_klen;
        n_k     = r_k;
        n_kidx  = r_kidx;
        n_i     = r_i;
        n_j     = r_j;
        n_sk    = r_sk;
        n_val   = r_val;
        n_hit   = r_hit;
        n_fin   = r_fin;
        n_keyed = r_keyed;
        n_valid = 1'b0;
        n_out   = r_out;
        p_ra    = r_k;
        p_we    = 1'b0;
        p_wa    = r_j;
        p_wd    = r_sk;
        j_new   = r_j + p_rd + r_key_q;
        t_addr  = r_sk + p_rd;
        ks      = r_hit ? r_sk : p_rd;
        case (r_state)
            ST_IDLE: begin
                // Prefetch S[i+1] for a possible crypt
                p_ra = r_i + 8'd1;
                // Finish previous crypt: second swap write and result
                if (r_fin) begin
                    p_we            = 1'b1;
                    p_wa            = r_j;
                    p_wd            = r_sk;
                    n_fin           = 1'b0;
                    n_valid         = 1'b1;
                    n_out.out_byte  = r_val ^ ks;
                    n_out.not_ready = 1'b0;
                end
                if (accept) begin
                    case (i_cmd.action)
                        ACT_INIT: begin
                            n_klen = eff_len;
                            n_k    = 8'd0;
                        end
                        ACT_CRYPT: begin
                            n_val = i_cmd.value;
                            if (!r_keyed) begin
                                n_valid         = 1'b1;
                                n_out.out_byte  = i_cmd.value;
                                n_out.not_ready = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                // Write identity, then seed the schedule
                p_we   = 1'b1;
                p_wa   = r_k;
                p_wd   = r_k;
                n_k    = r_k + 8'd1;
                n_j    = 8'd0;
                n_sk   = 8'd0;
                n_kidx = '0;
            end
            ST_KS_RD: begin
                // Read S[k]; retire previous step's S[j] write
                p_ra = r_k;
                p_we = 1'b1;
                p_wa = r_j;
                p_wd = r_sk;
            end
            ST_KS_J: begin
                p_ra = j_new;
                n_j  = j_new;
                n_sk = p_rd;
            end
            ST_KS_SWAP: begin
                p_we = 1'b1;
                p_wa = r_k;
                p_wd = p_rd;
                n_k  = r_k + 8'd1;
                if (9'(r_kidx) + 9'd1 == r_klen) begin
                    n_kidx = '0;
                end else begin
                    n_kidx = r_kidx + KA_W'(1);
                end
            end
            ST_KS_FIN: begin
                p_we    = 1'b1;
                p_wa    = r_j;
                p_wd    = r_sk;
                n_i     = 8'd0;
                n_j     = 8'd0;
                n_keyed = 1'b1;
            end
            ST_CR_J: begin
                // S[i+1] is here: advance i and j, read S[j]
                n_i  = r_i + 8'd1;
                p_ra = r_j + p_rd;
                n_j  = r_j + p_rd;
                n_sk = p_rd;
            end
            ST_CR_T: begin
                // Write S[i] <= S[j], read keystream entry
                p_we  = 1'b1;
                p_wa  = r_i;
                p_wd  = p_rd;
                p_ra  = t_addr;
                n_hit = (t_addr == r_j);
                n_fin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_key_length <= KEY_LEN_RESET;
            r_klen       <= KEY_LEN_RESET;
            r_k          <= 8'd0;
            r_kidx       <= '0;
            r_i          <= 8'd0;
            r_j          <= 8'd0;
            r_sk         <= 8'd0;
            r_hit        <= 1'b0;
            r_fin        <= 1'b0;
            r_keyed      <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_key_length <= i_cfg_data;
            end
            r_klen  <= n_klen;
            r_k     <= n_k;
            r_kidx  <= n_kidx;
            r_i     <= n_i;
            r_j     <= n_j;
            r_sk    <= n_sk;
            r_hit   <= n_hit;
            r_fin   <= n_fin;
            r_keyed <= n_keyed;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    // A result comes only from a finished crypt or an unkeyed crypt accept
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state == ST_IDLE && r_fin)
                  || $past(accept && i_cmd.action == ACT_CRYPT && !r_keyed)))
        else $error("result strobe without a source transaction");

    // Keystream path runs only after a key schedule
    a_crypt_keyed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CR_J) |-> r_keyed)
        else $error("crypt sequence entered while not keyed");

    // Pending swap write is only held into the idle cycle
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> (r_state == ST_IDLE))
        else $error("pending crypt write outside idle");

    // Key schedule end clears both counters
    a_ks_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_FIN) |=> (r_i == 8'd0 && r_j == 8'd0 && r_keyed))
        else $error("counters not cleared after key schedule");

    // Not-ready results only while no schedule has run
    a_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.not_ready) |-> !r_keyed)
        else $error("not-ready result while keyed");
`endif

endmodule
